### hdl/lns_dot_product_accumulator_core_defines.svh
// Assertion macros for the LNS dot product core.
// Each expects clk and rst_n in the scope where it is used.
`ifndef LNS_DOT_PRODUCT_ACCUMULATOR_CORE_DEFINES_SVH
`define LNS_DOT_PRODUCT_ACCUMULATOR_CORE_DEFINES_SVH

`ifndef ASSERT_OFF

// Same-cycle implication
`define LNS_DP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lns_dp: check failed");

// Next-cycle implication
`define LNS_DP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lns_dp: check failed");

`else

`define LNS_DP_ASSERT_IMP(lbl, ante, cons)
`define LNS_DP_ASSERT_NXT(lbl, ante, cons)

`endif

`endif

### hdl/lns_dp_pkg.sv
`default_nettype none

package lns_dp_pkg;

    // Number format and table size
    localparam int TABLE_DEPTH = 4096;
    localparam int LOG_WIDTH   = 24;
    localparam int FRAC_BITS   = 12;

    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int ENTRY_W = 12;
    localparam int DL_W    = 8;
    localparam int STEPS_W = 13;

    // Index datapath widths
    localparam int LIMIT_W  = DL_W + FRAC_BITS;
    localparam int CMP_W    = (LOG_WIDTH > LIMIT_W) ? LOG_WIDTH : LIMIT_W;
    localparam int PROD_W   = LIMIT_W + STEPS_W;
    localparam int SCALED_W = PROD_W + 1 - FRAC_BITS;

    // Stream layout: input tdata fields from the lowest bit up
    localparam int A_SIGN_LSB  = 0;
    localparam int A_LOG_LSB   = A_SIGN_LSB + 1;
    localparam int B_SIGN_LSB  = A_LOG_LSB + LOG_WIDTH;
    localparam int B_LOG_LSB   = B_SIGN_LSB + 1;
    localparam int E_IDX_LSB   = B_LOG_LSB + LOG_WIDTH;
    localparam int E_VAL_LSB   = E_IDX_LSB + ENTRY_W;
    localparam int IN_USED_W   = E_VAL_LSB + LOG_WIDTH;
    localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;
    localparam int OUT_USED_W  = 1 + LOG_WIDTH;
    localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_USED_W;
    localparam int FUNC_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = STEPS_W;

    typedef logic signed [LOG_WIDTH-1:0] log_t;
    typedef logic [IDX_W-1:0]            idx_t;

    localparam log_t LOG_MAX = log_t'({1'b0, {(LOG_WIDTH-1){1'b1}}});
    localparam log_t LOG_MIN = log_t'({1'b1, {(LOG_WIDTH-1){1'b0}}});

    typedef enum logic [FUNC_W-1:0] {
        FUNC_WR_PLUS  = 2'd0,
        FUNC_WR_MINUS = 2'd1,
        FUNC_MAC      = 2'd2
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DIFF_LIMIT     = 1'b0,
        CFG_STEPS_PER_UNIT = 1'b1
    } cfg_idx_t;

    typedef enum logic {
        PH_ISSUE = 1'b0,
        PH_MERGE = 1'b1
    } phase_t;

    // Lookup results handed from the index unit to the accumulator
    typedef struct packed {
        idx_t idx;
        log_t hi;
        logic same_sign;
        logic new_sign;
    } lookup_t;

    // Saturating add of two logs
    function automatic log_t sat_add(input log_t a, input log_t b);
        logic signed [LOG_WIDTH:0] s;
        s = {a[LOG_WIDTH-1], a} + {b[LOG_WIDTH-1], b};
        if (s[LOG_WIDTH] != s[LOG_WIDTH-1])
            return s[LOG_WIDTH] ? LOG_MIN : LOG_MAX;
        return log_t'(s[LOG_WIDTH-1:0]);
    endfunction

    // Entry address as seen by the table, and whether it falls inside it
    function automatic idx_t entry_addr(input logic [ENTRY_W-1:0] e);
        logic [ENTRY_W+IDX_W-1:0] t;
        t = {{IDX_W{1'b0}}, e};
        return t[IDX_W-1:0];
    endfunction

    function automatic logic entry_in_range(input logic [ENTRY_W-1:0] e);
        logic [ENTRY_W+IDX_W-1:0] t;
        t = {{IDX_W{1'b0}}, e};
        return t < (ENTRY_W+IDX_W)'(TABLE_DEPTH);
    endfunction

endpackage

`default_nettype wire

### hdl/lns_dp_ram.sv
`default_nettype none

// Simple dual-port table: one write port, one registered read port
module lns_dp_ram #(
    parameter int DEPTH = 4096,
    parameter int WIDTH = 24
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Read port, data held while re is low
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

### hdl/lns_dp_lookup.sv
`default_nettype none

// Compare accumulator and term, form the clamped and scaled table index
module lns_dp_lookup (
    input  wire logic                              acc_sign,
    input  wire lns_dp_pkg::log_t                  acc_log,
    input  wire logic                              term_sign,
    input  wire lns_dp_pkg::log_t                  term_log,
    input  wire logic [lns_dp_pkg::DL_W-1:0]       diff_limit,
    input  wire logic [lns_dp_pkg::STEPS_W-1:0]    steps_per_unit,
    output lns_dp_pkg::lookup_t                    lookup
);

    logic                                 acc_gt;
    lns_dp_pkg::log_t                     hi;
    lns_dp_pkg::log_t                     lo;
    logic [lns_dp_pkg::LOG_WIDTH:0]       diff_full;
    logic [lns_dp_pkg::LOG_WIDTH-1:0]     diff;
    logic [lns_dp_pkg::LIMIT_W-1:0]       limit;
    logic [lns_dp_pkg::CMP_W-1:0]         diff_x;
    logic [lns_dp_pkg::CMP_W-1:0]         limit_x;
    logic [lns_dp_pkg::LIMIT_W-1:0]       clamped;
    logic [lns_dp_pkg::PROD_W-1:0]        prod;
    logic [lns_dp_pkg::PROD_W:0]          prod_rnd;
    logic [lns_dp_pkg::SCALED_W-1:0]      scaled;

    // Pick the larger log; the difference is never negative
    always_comb
    begin
        acc_gt    = acc_log > term_log;
        hi        = acc_gt ? acc_log : term_log;
        lo        = acc_gt ? term_log : acc_log;
        diff_full = {hi[lns_dp_pkg::LOG_WIDTH-1], hi} - {lo[lns_dp_pkg::LOG_WIDTH-1], lo};
        diff      = diff_full[lns_dp_pkg::LOG_WIDTH-1:0];
    end

    // Clamp to the limit, scale by steps per unit, round half up
    always_comb
    begin
        limit    = {diff_limit, {lns_dp_pkg::FRAC_BITS{1'b0}}};
        diff_x   = lns_dp_pkg::CMP_W'(diff);
        limit_x  = lns_dp_pkg::CMP_W'(limit);
        clamped  = (diff_x > limit_x) ? limit : diff_x[lns_dp_pkg::LIMIT_W-1:0];
        prod     = lns_dp_pkg::PROD_W'(clamped) * lns_dp_pkg::PROD_W'(steps_per_unit);
        prod_rnd = {1'b0, prod}
                 + (lns_dp_pkg::PROD_W+1)'(1 << (lns_dp_pkg::FRAC_BITS - 1));
        scaled   = prod_rnd[lns_dp_pkg::PROD_W:lns_dp_pkg::FRAC_BITS];
    end

    // Saturate the index at the last entry, settle the result sign
    always_comb
    begin
        if (scaled >= lns_dp_pkg::SCALED_W'(lns_dp_pkg::TABLE_DEPTH))
            lookup.idx = lns_dp_pkg::IDX_W'(lns_dp_pkg::TABLE_DEPTH - 1);
        else
            lookup.idx = scaled[lns_dp_pkg::IDX_W-1:0];
        lookup.hi        = hi;
        lookup.same_sign = (acc_sign == term_sign);
        lookup.new_sign  = (acc_sign == term_sign || acc_gt) ? acc_sign : term_sign;
    end

endmodule

`default_nettype wire

### hdl/lns_dot_product_accumulator_core.sv
// Channel  Signals                                  Carries
// s_axis   tvalid tready tdata tuser tlast          table writes and product terms
// m_axis   tvalid tready tdata                      dot product result
// cfg      cfg_valid cfg_ready cfg_index cfg_data   register writes, always ready
//
// A table write, an ignored code or the first term of a run needs no table read.
// A later term goes through an issue phase, with the index and table read, then a
// merge phase with the merge add into the accumulator; the loop through the accumulator sets this.
// Reset clears the accumulator and run flag and loads diff_limit 8 and 256
// steps per unit; the tables hold nothing until written and need no sweep.
// A result waits in the output register; items keep entering until a run's
// last term finds that register still full.
`default_nettype none
`include "lns_dot_product_accumulator_core_defines.svh"

module lns_dot_product_accumulator_core (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // a_sign, a_log, b_sign, b_log, entry_index, entry_value, zero fill
    input  wire logic [lns_dp_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // func
    input  wire logic [lns_dp_pkg::FUNC_W-1:0]        s_axis_tuser,
    input  wire logic                                 s_axis_tlast,
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // sum_sign, sum_log, zero fill
    output logic [lns_dp_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [lns_dp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [lns_dp_pkg::CFG_DATA_W-1:0]    cfg_data
);

    // Configuration
    logic [lns_dp_pkg::DL_W-1:0]       diff_limit_reg;
    logic [lns_dp_pkg::STEPS_W-1:0]    steps_reg;

    // Item stage
    logic                              s1_valid_reg;
    lns_dp_pkg::func_t                 s1_func_reg;
    logic                              s1_psign_reg;
    lns_dp_pkg::log_t                  s1_plog_reg;
    logic                              s1_last_reg;
    logic [lns_dp_pkg::ENTRY_W-1:0]    s1_entry_idx_reg;
    lns_dp_pkg::log_t                  s1_entry_val_reg;

    // Lookup stage and accumulator
    lns_dp_pkg::phase_t                phase_reg;
    lns_dp_pkg::phase_t                phase_next;
    lns_dp_pkg::log_t                  hi_reg;
    logic                              same_reg;
    logic                              new_sign_reg;
    logic                              acc_sign_reg;
    lns_dp_pkg::log_t                  acc_log_reg;
    logic                              run_open_reg;

    // Output register
    logic                              out_valid_reg;
    logic                              out_sign_reg;
    lns_dp_pkg::log_t                  out_log_reg;

    logic                              in_fire;
    lns_dp_pkg::log_t                  in_a_log;
    lns_dp_pkg::log_t                  in_b_log;
    logic                              s1_mac;
    logic                              s1_wr_plus;
    logic                              s1_wr_minus;
    logic                              long_op;
    logic                              out_room;
    logic                              s1_done;
    logic                              rd_issue;
    lns_dp_pkg::lookup_t               lookup;
    lns_dp_pkg::idx_t                  wr_addr;
    logic                              wr_ok;
    logic [lns_dp_pkg::LOG_WIDTH-1:0]  plus_q;
    logic [lns_dp_pkg::LOG_WIDTH-1:0]  minus_q;
    lns_dp_pkg::log_t                  merge_log;
    logic                              new_acc_sign;
    lns_dp_pkg::log_t                  new_acc_log;

    // Handshake and item decode
    always_comb
    begin
        in_fire     = s_axis_tvalid && s_axis_tready;
        in_a_log    = lns_dp_pkg::log_t'(
                      s_axis_tdata[lns_dp_pkg::A_LOG_LSB +: lns_dp_pkg::LOG_WIDTH]);
        in_b_log    = lns_dp_pkg::log_t'(
                      s_axis_tdata[lns_dp_pkg::B_LOG_LSB +: lns_dp_pkg::LOG_WIDTH]);
        s1_mac      = s1_valid_reg && (s1_func_reg == lns_dp_pkg::FUNC_MAC);
        s1_wr_plus  = s1_valid_reg && (s1_func_reg == lns_dp_pkg::FUNC_WR_PLUS);
        s1_wr_minus = s1_valid_reg && (s1_func_reg == lns_dp_pkg::FUNC_WR_MINUS);
        long_op     = s1_mac && run_open_reg;
        out_room    = !out_valid_reg || m_axis_tready;
        s1_done     = s1_valid_reg
                   && (!long_op || (phase_reg == lns_dp_pkg::PH_MERGE))
                   && (!(s1_mac && s1_last_reg) || out_room);
        rd_issue    = long_op && (phase_reg == lns_dp_pkg::PH_ISSUE);
        s_axis_tready = !s1_valid_reg || s1_done;
        cfg_ready   = 1'b1;
        wr_addr     = lns_dp_pkg::entry_addr(s1_entry_idx_reg);
        wr_ok       = lns_dp_pkg::entry_in_range(s1_entry_idx_reg);
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            diff_limit_reg <= lns_dp_pkg::DL_W'(8);
            steps_reg      <= lns_dp_pkg::STEPS_W'(256);
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (lns_dp_pkg::cfg_idx_t'(cfg_index))
                lns_dp_pkg::CFG_DIFF_LIMIT:     diff_limit_reg <= cfg_data[lns_dp_pkg::DL_W-1:0];
                lns_dp_pkg::CFG_STEPS_PER_UNIT: steps_reg      <= cfg_data;
                default:                        ;
            endcase
        end
    end

    // Item stage: hold until done, form product sign and log on entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_func_reg      <= lns_dp_pkg::func_t'(s_axis_tuser);
            s1_psign_reg     <= (s_axis_tdata[lns_dp_pkg::A_SIGN_LSB]
                                 == s_axis_tdata[lns_dp_pkg::B_SIGN_LSB]);
            s1_plog_reg      <= lns_dp_pkg::sat_add(in_a_log, in_b_log);
            s1_last_reg      <= s_axis_tlast;
            s1_entry_idx_reg <= s_axis_tdata[lns_dp_pkg::E_IDX_LSB +: lns_dp_pkg::ENTRY_W];
            s1_entry_val_reg <= lns_dp_pkg::log_t'(
                                s_axis_tdata[lns_dp_pkg::E_VAL_LSB +: lns_dp_pkg::LOG_WIDTH]);
        end
    end

    // Index unit
    lns_dp_lookup u_lookup (
        .acc_sign       (acc_sign_reg),
        .acc_log        (acc_log_reg),
        .term_sign      (s1_psign_reg),
        .term_log       (s1_plog_reg),
        .diff_limit     (diff_limit_reg),
        .steps_per_unit (steps_reg),
        .lookup         (lookup)
    );

    // Correction tables
    lns_dp_ram #(
        .DEPTH (lns_dp_pkg::TABLE_DEPTH),
        .WIDTH (lns_dp_pkg::LOG_WIDTH)
    ) u_plus_ram (
        .clk   (clk),
        .we    (s1_wr_plus && wr_ok),
        .waddr (wr_addr),
        .wdata (s1_entry_val_reg),
        .re    (rd_issue),
        .raddr (lookup.idx),
        .rdata (plus_q)
    );

    lns_dp_ram #(
        .DEPTH (lns_dp_pkg::TABLE_DEPTH),
        .WIDTH (lns_dp_pkg::LOG_WIDTH)
    ) u_minus_ram (
        .clk   (clk),
        .we    (s1_wr_minus && wr_ok),
        .waddr (wr_addr),
        .wdata (s1_entry_val_reg),
        .re    (rd_issue),
        .raddr (lookup.idx),
        .rdata (minus_q)
    );

    // Phase of a later term that reads the table
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            phase_reg <= lns_dp_pkg::PH_ISSUE;
        else
            phase_reg <= phase_next;
    end

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            lns_dp_pkg::PH_ISSUE:
                if (rd_issue)
                    phase_next = lns_dp_pkg::PH_MERGE;
            lns_dp_pkg::PH_MERGE:
                if (s1_done)
                    phase_next = lns_dp_pkg::PH_ISSUE;
            default:
                phase_next = lns_dp_pkg::PH_ISSUE;
        endcase
    end

    // Hold lookup results alongside the table read
    always_ff @(posedge clk)
    begin
        if (rd_issue)
        begin
            hi_reg       <= lookup.hi;
            same_reg     <= lookup.same_sign;
            new_sign_reg <= lookup.new_sign;
        end
    end

    // Merge: larger log plus correction, or load on the first term of a run
    always_comb
    begin
        merge_log = lns_dp_pkg::sat_add(hi_reg,
                    lns_dp_pkg::log_t'(same_reg ? plus_q : minus_q));
        if (run_open_reg)
        begin
            new_acc_sign = new_sign_reg;
            new_acc_log  = merge_log;
        end
        else
        begin
            new_acc_sign = s1_psign_reg;
            new_acc_log  = s1_plog_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_sign_reg <= 1'b0;
            acc_log_reg  <= '0;
            run_open_reg <= 1'b0;
        end
        else if (s1_done && s1_mac)
        begin
            acc_sign_reg <= new_acc_sign;
            acc_log_reg  <= new_acc_log;
            run_open_reg <= !s1_last_reg;
        end
    end

    // Output register: load on a last term, drop when the beat is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (s1_done && s1_mac && s1_last_reg)
            out_valid_reg <= 1'b1;
        else if (m_axis_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_done && s1_mac && s1_last_reg)
        begin
            out_sign_reg <= new_acc_sign;
            out_log_reg  <= new_acc_log;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{lns_dp_pkg::OUT_PAD_W{1'b0}}, out_log_reg, out_sign_reg};

    // Checks
    `LNS_DP_ASSERT_IMP(a_merge_has_term, phase_reg == lns_dp_pkg::PH_MERGE,
                       s1_valid_reg && long_op)
    `LNS_DP_ASSERT_IMP(a_issue_blocks_input, rd_issue, !s_axis_tready)
    `LNS_DP_ASSERT_NXT(a_last_closes_run, s1_done && s1_mac && s1_last_reg,
                       m_axis_tvalid && !run_open_reg)

endmodule

`default_nettype wire
